// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the checker file ftpr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, muted while reset is high.
`define FTPR_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge, active during reset too.
`define FTPR_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ftpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ftpr_pkg
// Shared types, constants and helpers of the frame time detail regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ftpr_pkg;

   // field widths
   localparam int IN_W       = 24;
   localparam int ANGLE_W    = 23;
   localparam int AVG_W      = 18;
   localparam int TERM_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // serial arithmetic units
   localparam int MUL_A_W   = 40;
   localparam int MUL_B_W   = 24;
   localparam int MUL_P_W   = 64;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int DIV_N_W   = 48;
   localparam int DIV_D_W   = 34;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // numeric constants
   localparam int unsigned TIMESCALE_US = 80000;
   localparam int unsigned CUSHION_MS8  = 768;
   localparam int unsigned RT_MIN       = 256;
   localparam int unsigned RT_MAX       = 256000;
   localparam int unsigned DELTA_MAX    = 1000000;
   localparam int unsigned ANGLE_MIN    = 66;
   localparam int unsigned ANGLE_MAX    = 5898240;
   localparam int unsigned ANGLE_RESET  = 32768;
   localparam int unsigned ONE_Q16      = 65536;
   localparam int unsigned FPS_MAX      = 65535;
   localparam int unsigned FPS_NUM      = 65536000;
   localparam int unsigned TARGET_MIN   = 128;
   localparam int unsigned TARGET_RESET = 16640;
   localparam int unsigned SCALE_MIN    = 256;
   localparam int unsigned GAIN_P_RESET = 65536;
   localparam int unsigned VSCALE_RESET = 65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_FPS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_SCALE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANCE_SCALE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_INIT     = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_SUM,
      ST_OUT
   } state_type;

   localparam int STEP_W = 5;

   typedef enum logic [STEP_W-1:0] {
      STEP_NB,
      STEP_SDEN,
      STEP_SB,
      STEP_FAVG1,
      STEP_FAVG2,
      STEP_SAVG1,
      STEP_SAVG2,
      STEP_FPSF,
      STEP_FPSS,
      STEP_DSQ,
      STEP_VAR,
      STEP_ESQ,
      STEP_NOISE,
      STEP_ENUM,
      STEP_E,
      STEP_EDT,
      STEP_INTEG,
      STEP_DE,
      STEP_DERIV,
      STEP_P,
      STEP_I,
      STEP_D
   } step_type;

   function automatic logic signed [TERM_W-1:0] sat32(input logic signed [64:0] x);
      if (x > 65'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -65'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[TERM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ftpr_mul.sv =====
// ----------------------------------------------------------------------------
// ftpr_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftpr_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftpr_pkg::MUL_A_W-1:0]  a,
   input  logic [ftpr_pkg::MUL_B_W-1:0]  b,
   output logic                          done,
   output logic [ftpr_pkg::MUL_P_W-1:0]  prod
);
   import ftpr_pkg::*;

   logic [MUL_P_W-1:0]   mcand_ff;
   logic [MUL_B_W-1:0]   mplier_ff;
   logic [MUL_P_W-1:0]   acc_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + MUL_CNT_W'(1);
            if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= MUL_P_W'(a);
         mplier_ff <= b;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[MUL_P_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MUL_B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ftpr_div.sv =====
// ----------------------------------------------------------------------------
// ftpr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftpr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftpr_pkg::DIV_N_W-1:0]  dividend,
   input  logic [ftpr_pkg::DIV_D_W-1:0]  divisor,
   output logic                          done,
   output logic [ftpr_pkg::DIV_N_W-1:0]  quot
);
   import ftpr_pkg::*;

   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W:0]     trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DIV_D_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_ff <= trial[DIV_D_W-1:0];
         end
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_time_pid_detail_regulator_core.sv =====
// ----------------------------------------------------------------------------
// frame_time_pid_detail_regulator_core
// PID regulation of a level-of-detail angle from per-frame timings.
// ----------------------------------------------------------------------------
//  - req_* channel: one transaction per frame carries the four frame timings
//    and the wall-clock delta. It is accepted when req_valid is high and
//    req_stall is low. req_stall is high while a transaction is being worked.
//  - rsp_* channel: one result per request, held until taken (rsp_valid high,
//    rsp_stall low). A new request is taken while a result waits; its own
//    result is only written once the previous one has left.
//  - csr_* channel: register writes, always ready; write only while idle.
//    Writing the angle_init register also reloads the angle state.
//  - Arithmetic: one bit-serial multiplier and one bit-serial divider do all
//    arithmetic, one step at a time. A frame that skips regulation ends after
//    the slow average; a regulated one runs every step. A stalled result that
//    still waits holds the block in its output state, so no request is taken.
//  - Reset (synchronous): registers return to their defaults, averages,
//    error history and term record clear, angle reloads to 0.5 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_time_pid_detail_regulator_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [ftpr_pkg::IN_W-1:0]        req_present_time,
   input  logic signed [ftpr_pkg::IN_W-1:0]        req_engine_time,
   input  logic signed [ftpr_pkg::IN_W-1:0]        req_batch_time,
   input  logic signed [ftpr_pkg::IN_W-1:0]        req_gpu_time,
   input  logic signed [ftpr_pkg::IN_W-1:0]        req_frame_delta_us,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ftpr_pkg::ANGLE_W-1:0]            rsp_lod_angle,
   output logic                                    rsp_angle_changed,
   output logic                                    rsp_regulated,
   output logic signed [ftpr_pkg::TERM_W-1:0]      rsp_p_term,
   output logic signed [ftpr_pkg::TERM_W-1:0]      rsp_i_term,
   output logic signed [ftpr_pkg::TERM_W-1:0]      rsp_d_term,
   output logic signed [ftpr_pkg::TERM_W-1:0]      rsp_pid_sum,
   output logic [ftpr_pkg::AVG_W-1:0]              rsp_fast_avg_ms,
   output logic [ftpr_pkg::AVG_W-1:0]              rsp_slow_avg_ms,
   // register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ftpr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ftpr_pkg::CSR_DATA_W-1:0]         csr_data
);
   import ftpr_pkg::*;

   function automatic logic [23:0] mag24(input logic signed [23:0] g);
      return g[23] ? 24'(-g) : 24'(g);
   endfunction

   // ---------------------------------------------------------------- config
   logic               auto_en_ff;
   logic [15:0]        target_ff;
   logic [15:0]        sscale_ff;
   logic signed [23:0] gain_p_ff;
   logic signed [23:0] gain_i_ff;
   logic signed [23:0] gain_d_ff;
   logic signed [23:0] vscale_ff;

   // ------------------------------------------------------------ controller
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      unit_start;
   logic      capture;
   logic      run_ok;

   // -------------------------------------------------------------- datapath
   logic [AVG_W-1:0]         rt_ff;
   logic [19:0]              delta_ff;
   logic [16:0]              nb_ff;
   logic [16:0]              sb_ff;
   logic [DIV_D_W-1:0]       sden_ff;
   logic [34:0]              blend_ff;
   logic [AVG_W-1:0]         fast_ff;
   logic [AVG_W-1:0]         slow_ff;
   logic [15:0]              fps_f_ff;
   logic [15:0]              fps_s_ff;
   logic [31:0]              dsq_ff;
   logic signed [48:0]       var_ff;
   logic [31:0]              esq_ff;
   logic [16:0]              noise_ff;
   logic [DIV_N_W-1:0]       tmp_ff;
   logic                     neg_ff;
   logic signed [17:0]       e_ff;
   logic signed [17:0]       last_error_ff;
   logic signed [17:0]       integ_ff;
   logic signed [38:0]       deriv_ff;
   logic [ANGLE_W-1:0]       angle_ff;
   logic signed [TERM_W-1:0] term_ff [4];
   logic                     reg_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [ANGLE_W-1:0]       rsp_angle_ff;
   logic                     rsp_changed_ff;
   logic                     rsp_reg_ff;
   logic signed [TERM_W-1:0] rsp_term_ff [4];
   logic [AVG_W-1:0]         rsp_fast_ff;
   logic [AVG_W-1:0]         rsp_slow_ff;

   // unit wiring
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic               mul_done;
   logic [DIV_N_W-1:0] div_n;
   logic [DIV_D_W-1:0] div_d;
   logic [DIV_N_W-1:0] div_q;
   logic               div_done;
   logic               use_div;
   logic               neg_in;
   logic               unit_done;

   // -------------------------------------------------- request conditioning
   // negative times clamp to zero; present time is capped by batch + 3 ms
   logic [22:0] pres_pos, eng_pos, bat_pos, gpu_pos;
   logic [23:0] cush, pres_cap, rt_max1, rt_max;
   logic [AVG_W-1:0] rt_clamp;
   logic [19:0] delta_clamp;

   assign pres_pos = req_present_time[IN_W-1] ? '0 : req_present_time[22:0];
   assign eng_pos  = req_engine_time[IN_W-1]  ? '0 : req_engine_time[22:0];
   assign bat_pos  = req_batch_time[IN_W-1]   ? '0 : req_batch_time[22:0];
   assign gpu_pos  = req_gpu_time[IN_W-1]     ? '0 : req_gpu_time[22:0];
   assign cush     = {1'b0, bat_pos} + 24'(CUSHION_MS8);
   assign pres_cap = ({1'b0, pres_pos} > cush) ? cush : {1'b0, pres_pos};
   assign rt_max1  = ({1'b0, eng_pos} > pres_cap) ? {1'b0, eng_pos} : pres_cap;
   assign rt_max   = ({1'b0, gpu_pos} > rt_max1) ? {1'b0, gpu_pos} : rt_max1;
   assign rt_clamp = (rt_max < 24'(RT_MIN)) ? AVG_W'(RT_MIN) :
                     (rt_max > 24'(RT_MAX)) ? AVG_W'(RT_MAX) : rt_max[AVG_W-1:0];
   assign delta_clamp = req_frame_delta_us[IN_W-1] ? '0 :
                        (req_frame_delta_us[22:0] > 23'(DELTA_MAX)) ? 20'(DELTA_MAX) :
                        req_frame_delta_us[19:0];

   // ------------------------------------------------------ derived operands
   logic [15:0]        tgt, ss;
   logic [16:0]        dt;
   logic signed [16:0] d_s, err_s;
   logic [16:0]        d_mag, err_mag, e_mag, integ_mag;
   logic signed [18:0] de_s;
   logic [17:0]        de_mag;
   logic [38:0]        deriv_mag;

   assign tgt       = (target_ff < 16'(TARGET_MIN)) ? 16'(TARGET_MIN) : target_ff;
   assign ss        = (sscale_ff < 16'(SCALE_MIN)) ? 16'(SCALE_MIN) : sscale_ff;
   assign dt        = (delta_ff < 20'(TIMESCALE_US)) ? delta_ff[16:0] : 17'(TIMESCALE_US);
   assign d_s       = $signed({1'b0, fps_s_ff}) - $signed({1'b0, fps_f_ff});
   assign d_mag     = d_s[16] ? 17'(-d_s) : 17'(d_s);
   assign err_s     = $signed({1'b0, tgt}) - $signed({1'b0, fps_s_ff});
   assign err_mag   = err_s[16] ? 17'(-err_s) : 17'(err_s);
   assign e_mag     = e_ff[17] ? 17'(-e_ff) : e_ff[16:0];
   assign integ_mag = integ_ff[17] ? 17'(-integ_ff) : integ_ff[16:0];
   assign de_s      = 19'(e_ff) - 19'(last_error_ff);
   assign de_mag    = de_s[18] ? 18'(-de_s) : de_s[17:0];
   assign deriv_mag = deriv_ff[38] ? 39'(-deriv_ff) : 39'(deriv_ff);

   // noise gate: compare err^2 against var and 2*var
   logic signed [50:0] esq_x, var_x, var2_x, gate_diff;
   assign esq_x     = $signed({19'd0, esq_ff});
   assign var_x     = 51'(var_ff);
   assign var2_x    = var_x <<< 1;
   assign gate_diff = esq_x - var_x;

   // ---------------------------------------------------- operand selection
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_n   = '0;
      div_d   = '0;
      use_div = 1'b0;
      neg_in  = neg_ff;
      unique case (step_ff)
         STEP_NB: begin
            use_div = 1'b1;
            div_n   = DIV_N_W'({delta_ff, 16'd0});
            div_d   = DIV_D_W'(TIMESCALE_US);
         end
         STEP_SDEN: begin
            mul_a = MUL_A_W'(ss);
            mul_b = MUL_B_W'(TIMESCALE_US);
         end
         STEP_SB: begin
            use_div = 1'b1;
            div_n   = DIV_N_W'({delta_ff, 24'd0});
            div_d   = sden_ff;
         end
         STEP_FAVG1: begin
            mul_a = MUL_A_W'(fast_ff);
            mul_b = MUL_B_W'(17'(ONE_Q16) - nb_ff);
         end
         STEP_FAVG2: begin
            mul_a = MUL_A_W'(rt_ff);
            mul_b = MUL_B_W'(nb_ff);
         end
         STEP_SAVG1: begin
            mul_a = MUL_A_W'(slow_ff);
            mul_b = MUL_B_W'(17'(ONE_Q16) - sb_ff);
         end
         STEP_SAVG2: begin
            mul_a = MUL_A_W'(rt_ff);
            mul_b = MUL_B_W'(sb_ff);
         end
         STEP_FPSF: begin
            use_div = 1'b1;
            div_n   = DIV_N_W'(FPS_NUM);
            div_d   = DIV_D_W'(fast_ff);
         end
         STEP_FPSS: begin
            use_div = 1'b1;
            div_n   = DIV_N_W'(FPS_NUM);
            div_d   = DIV_D_W'(slow_ff);
         end
         STEP_DSQ: begin
            mul_a = MUL_A_W'(d_mag);
            mul_b = MUL_B_W'(d_mag);
         end
         STEP_VAR: begin
            mul_a  = MUL_A_W'(dsq_ff);
            mul_b  = mag24(vscale_ff);
            neg_in = vscale_ff[23];
         end
         STEP_ESQ: begin
            mul_a = MUL_A_W'(err_mag);
            mul_b = MUL_B_W'(err_mag);
         end
         STEP_NOISE: begin
            use_div = 1'b1;
            div_n   = {gate_diff[31:0], 16'd0};
            div_d   = var_ff[DIV_D_W-1:0];
         end
         STEP_ENUM: begin
            mul_a = MUL_A_W'(err_mag);
            mul_b = MUL_B_W'(noise_ff);
         end
         STEP_E: begin
            use_div = 1'b1;
            div_n   = tmp_ff;
            div_d   = DIV_D_W'(tgt);
            neg_in  = err_s[16];
         end
         STEP_EDT: begin
            mul_a  = MUL_A_W'(e_mag);
            mul_b  = MUL_B_W'(dt);
            neg_in = e_ff[17];
         end
         STEP_INTEG: begin
            use_div = 1'b1;
            div_n   = tmp_ff;
            div_d   = DIV_D_W'(DELTA_MAX);
         end
         STEP_DE: begin
            mul_a  = MUL_A_W'(de_mag);
            mul_b  = MUL_B_W'(DELTA_MAX);
            neg_in = de_s[18];
         end
         STEP_DERIV: begin
            use_div = 1'b1;
            div_n   = tmp_ff;
            div_d   = DIV_D_W'(dt);
         end
         STEP_P: begin
            mul_a  = MUL_A_W'(e_mag);
            mul_b  = mag24(gain_p_ff);
            neg_in = e_ff[17] ^ gain_p_ff[23];
         end
         STEP_I: begin
            mul_a  = MUL_A_W'(integ_mag);
            mul_b  = mag24(gain_i_ff);
            neg_in = integ_ff[17] ^ gain_i_ff[23];
         end
         STEP_D: begin
            mul_a  = MUL_A_W'(deriv_mag);
            mul_b  = mag24(gain_d_ff);
            neg_in = deriv_ff[38] ^ gain_d_ff[23];
         end
         default: begin
            use_div = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------- shared units
   ftpr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (unit_start && !use_div),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ftpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start && use_div),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quot     (div_q)
   );

   assign unit_done = mul_done || div_done;

   // ------------------------------------------------------ result shaping
   logic signed [64:0]  prod_s, prod_sh;
   logic signed [48:0]  quot_s;
   logic [35:0]         blend_sum;
   logic [19:0]         blend_q;
   logic [AVG_W-1:0]    blend_new;
   logic [15:0]         fps_new;
   logic signed [17:0]  e_new;
   logic signed [49:0]  isum;
   logic signed [17:0]  integ_new;
   logic [16:0]         noise_new;

   assign prod_s  = neg_ff ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
   assign prod_sh = prod_s >>> 16;
   assign quot_s  = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

   // rounded blend, capped at the render time ceiling
   assign blend_sum = 36'(blend_ff) + 36'(mul_prod[34:0]) + 36'd32768;
   assign blend_q   = blend_sum[35:16];
   assign blend_new = (blend_q > 20'(RT_MAX)) ? AVG_W'(RT_MAX) : blend_q[AVG_W-1:0];

   assign fps_new = (div_q > DIV_N_W'(FPS_MAX)) ? 16'(FPS_MAX) : div_q[15:0];

   assign e_new = (quot_s > 49'sd65536)  ? 18'sd65536 :
                  (quot_s < -49'sd65536) ? -18'sd65536 : quot_s[17:0];

   assign isum      = 50'(integ_ff) + 50'(quot_s);
   assign integ_new = (isum > 50'sd65536)  ? 18'sd65536 :
                      (isum < -50'sd65536) ? -18'sd65536 : isum[17:0];

   // below var: gate shut; up to 2*var: ramp; beyond: fully open
   assign noise_new = (esq_x < var_x)  ? 17'd0 :
                      (esq_x < var2_x) ? div_q[16:0] : 17'(ONE_Q16);

   assign run_ok = auto_en_ff && (delta_ff != '0) && (fast_ff != '0) && (blend_new != '0);

   // ---------------------------------------------------- angle update
   logic signed [64:0]  sum3;
   logic signed [33:0]  asum;
   logic [ANGLE_W-1:0]  angle_new;

   assign sum3 = 65'(term_ff[0]) + 65'(term_ff[1]) + 65'(term_ff[2]);
   assign asum = $signed({11'd0, angle_ff}) + 34'(term_ff[3]);
   assign angle_new = (asum < 34'sd66)      ? ANGLE_W'(ANGLE_MIN) :
                      (asum > 34'sd5898240) ? ANGLE_W'(ANGLE_MAX) : asum[ANGLE_W-1:0];

   // ---------------------------------------------------- state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_NB;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      unit_start = 1'b0;
      capture    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               step_in  = STEP_NB;
            end
         end
         ST_RUN: begin
            unit_start = 1'b1;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               capture = 1'b1;
               if (step_ff == STEP_SAVG2 && !run_ok) begin
                  state_in = ST_OUT;
               end else if (step_ff == STEP_D) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_RUN;
                  step_in  = step_type'(step_ff + STEP_W'(1));
               end
            end
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // ------------------------------------------ config and regulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_en_ff    <= 1'b1;
         target_ff     <= 16'(TARGET_RESET);
         sscale_ff     <= 16'(SCALE_MIN);
         gain_p_ff     <= 24'(GAIN_P_RESET);
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         vscale_ff     <= 24'(VSCALE_RESET);
         angle_ff      <= ANGLE_W'(ANGLE_RESET);
         fast_ff       <= '0;
         slow_ff       <= '0;
         last_error_ff <= '0;
         integ_ff      <= '0;
         reg_ff        <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            term_ff[k] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_AUTO_ENABLE:    auto_en_ff <= csr_data[0];
               CSR_TARGET_FPS:     target_ff  <= csr_data[15:0];
               CSR_SMOOTH_SCALE:   sscale_ff  <= csr_data[15:0];
               CSR_GAIN_P:         gain_p_ff  <= csr_data;
               CSR_GAIN_I:         gain_i_ff  <= csr_data;
               CSR_GAIN_D:         gain_d_ff  <= csr_data;
               CSR_VARIANCE_SCALE: vscale_ff  <= csr_data;
               CSR_ANGLE_INIT: begin
                  if (csr_data[ANGLE_W-1:0] < ANGLE_W'(ANGLE_MIN)) begin
                     angle_ff <= ANGLE_W'(ANGLE_MIN);
                  end else if (csr_data[ANGLE_W-1:0] > ANGLE_W'(ANGLE_MAX)) begin
                     angle_ff <= ANGLE_W'(ANGLE_MAX);
                  end else begin
                     angle_ff <= csr_data[ANGLE_W-1:0];
                  end
               end
               default: ;
            endcase
         end
         if (capture) begin
            case (step_ff)
               STEP_FAVG2: fast_ff <= blend_new;
               STEP_SAVG2: begin
                  slow_ff <= blend_new;
                  reg_ff  <= run_ok;
               end
               STEP_INTEG: integ_ff <= integ_new;
               STEP_DERIV: last_error_ff <= e_ff;
               STEP_P:     term_ff[0] <= sat32(prod_sh);
               STEP_I:     term_ff[1] <= sat32(prod_sh);
               STEP_D:     term_ff[2] <= sat32(prod_sh);
               default: ;
            endcase
         end
         if (state_ff == ST_SUM) begin
            term_ff[3] <= sat32(sum3);
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall) && reg_ff) begin
            angle_ff <= angle_new;
         end
      end
   end

   // ------------------------------------------------ working registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         rt_ff    <= rt_clamp;
         delta_ff <= delta_clamp;
      end
      if (unit_start) begin
         neg_ff <= neg_in;
      end
      if (capture) begin
         case (step_ff)
            STEP_NB: nb_ff <= (delta_ff < 20'(TIMESCALE_US)) ? div_q[16:0] : 17'(ONE_Q16);
            STEP_SDEN: sden_ff <= mul_prod[DIV_D_W-1:0];
            STEP_SB: begin
               sb_ff <= (DIV_D_W'({delta_ff, 8'd0}) < sden_ff) ? div_q[16:0]
                                                                 : 17'(ONE_Q16);
            end
            STEP_FAVG1, STEP_SAVG1: blend_ff <= mul_prod[34:0];
            STEP_FPSF:  fps_f_ff <= fps_new;
            STEP_FPSS:  fps_s_ff <= fps_new;
            STEP_DSQ:   dsq_ff   <= mul_prod[31:0];
            STEP_VAR:   var_ff   <= prod_sh[48:0];
            STEP_ESQ:   esq_ff   <= mul_prod[31:0];
            STEP_NOISE: noise_ff <= noise_new;
            STEP_ENUM, STEP_EDT, STEP_DE: tmp_ff <= mul_prod[DIV_N_W-1:0];
            STEP_E:     e_ff     <= e_new;
            STEP_DERIV: deriv_ff <= quot_s[38:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_angle_ff   <= reg_ff ? angle_new : angle_ff;
         rsp_changed_ff <= reg_ff && (angle_new != angle_ff);
         rsp_reg_ff     <= reg_ff;
         rsp_fast_ff    <= fast_ff;
         rsp_slow_ff    <= slow_ff;
         for (int k = 0; k < 4; k++) begin
            rsp_term_ff[k] <= term_ff[k];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lod_angle     = rsp_angle_ff;
   assign rsp_angle_changed = rsp_changed_ff;
   assign rsp_regulated     = rsp_reg_ff;
   assign rsp_p_term        = rsp_term_ff[0];
   assign rsp_i_term        = rsp_term_ff[1];
   assign rsp_d_term        = rsp_term_ff[2];
   assign rsp_pid_sum       = rsp_term_ff[3];
   assign rsp_fast_avg_ms   = rsp_fast_ff;
   assign rsp_slow_avg_ms   = rsp_slow_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ftpr_checker.sv =====
// ----------------------------------------------------------------------------
// ftpr_checker
// Port-level assertions for the detail regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ftpr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ftpr_pkg::ANGLE_W-1:0]       rsp_lod_angle,
   input logic                               rsp_angle_changed,
   input logic                               rsp_regulated
);
   import ftpr_pkg::*;

   // one transaction in work at a time
   `FTPR_ASSERT_RST(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall, "request accepted while busy")

   `FTPR_ASSERT(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

   `FTPR_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_lod_angle)), "stalled response changed")

   `FTPR_ASSERT_RST(a_angle_range, clock, reset, rsp_valid |-> (rsp_lod_angle >= 23'd66 && rsp_lod_angle <= 23'd5898240), "angle out of range")

   `FTPR_ASSERT_RST(a_change_needs_pid, clock, reset, (rsp_valid && rsp_angle_changed) |-> rsp_regulated, "angle changed without regulation")

endmodule

bind frame_time_pid_detail_regulator_core ftpr_checker u_ftpr_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame time PID detail regulator core. A queued
// driver sends frame timing transactions with random gaps. A monitor takes
// results under random stall and checks every field against an in-bench
// fixed-point model of the regulator.
// ----------------------------------------------------------------------------

module tb_top;
   import ftpr_pkg::*;

   typedef struct {
      logic signed [IN_W-1:0] present;
      logic signed [IN_W-1:0] engine;
      logic signed [IN_W-1:0] batch;
      logic signed [IN_W-1:0] gpu;
      logic signed [IN_W-1:0] delta;
   } frame_type;

   typedef struct {
      logic [ANGLE_W-1:0]       angle;
      logic                     changed;
      logic                     regulated;
      logic signed [TERM_W-1:0] p;
      logic signed [TERM_W-1:0] i;
      logic signed [TERM_W-1:0] d;
      logic signed [TERM_W-1:0] sum;
      logic [AVG_W-1:0]         fast;
      logic [AVG_W-1:0]         slow;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [IN_W-1:0]   req_present_time = '0;
   logic signed [IN_W-1:0]   req_engine_time = '0;
   logic signed [IN_W-1:0]   req_batch_time = '0;
   logic signed [IN_W-1:0]   req_gpu_time = '0;
   logic signed [IN_W-1:0]   req_frame_delta_us = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]       rsp_lod_angle;
   logic                     rsp_angle_changed;
   logic                     rsp_regulated;
   logic signed [TERM_W-1:0] rsp_p_term;
   logic signed [TERM_W-1:0] rsp_i_term;
   logic signed [TERM_W-1:0] rsp_d_term;
   logic signed [TERM_W-1:0] rsp_pid_sum;
   logic [AVG_W-1:0]         rsp_fast_avg_ms;
   logic [AVG_W-1:0]         rsp_slow_avg_ms;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   frame_time_pid_detail_regulator_core dut (.*);

   always #1 clock = ~clock;

   // frames waiting to be sent, and results owed by the block
   frame_type        frames_to_send[$];
   frame_result_type results_due[$];
   frame_type        cur_frame;
   int               gap_left = 0;
   int               stall_left = 0;
   bit               calm = 1'b0;
   int               mismatches = 0;
   int               frames_sent = 0;
   int               results_seen = 0;
   int               regulated_seen = 0;
   int               moves_seen = 0;

   // mirror of the control registers
   longint cfg_enable, cfg_target, cfg_smooth, cfg_kp, cfg_ki, cfg_kd, cfg_vscale;
   // mirror of the regulator state
   longint fast_avg, slow_avg, last_err, err_integral, lod;
   longint term_rec[4];

   function automatic longint clampl(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint sat_term(longint x);
      return clampl(x, -64'sd2147483648, 64'sd2147483647);
   endfunction

   // time-weighted average, Q1.16 weight, rounded
   function automatic longint blend_avg(longint avg, longint w, longint rt);
      return clampl(((ONE_Q16 - w) * avg + w * rt + 32768) >> 16, 0, RT_MAX);
   endfunction

   function automatic longint fps_from(longint avg);
      return clampl(FPS_NUM / avg, 0, FPS_MAX);
   endfunction

   function automatic longint sext24(logic [CSR_DATA_W-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic void mirror_reset();
      cfg_enable = 1; cfg_target = TARGET_RESET; cfg_smooth = SCALE_MIN;
      cfg_kp = GAIN_P_RESET; cfg_ki = 0; cfg_kd = 0; cfg_vscale = VSCALE_RESET;
      fast_avg = 0; slow_avg = 0; last_err = 0; err_integral = 0;
      lod = ANGLE_RESET;
      foreach (term_rec[k]) term_rec[k] = 0;
   endfunction

   function automatic void mirror_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_AUTO_ENABLE:    cfg_enable = v[0];
         CSR_TARGET_FPS:     cfg_target = v[15:0];
         CSR_SMOOTH_SCALE:   cfg_smooth = v[15:0];
         CSR_GAIN_P:         cfg_kp = sext24(v);
         CSR_GAIN_I:         cfg_ki = sext24(v);
         CSR_GAIN_D:         cfg_kd = sext24(v);
         CSR_VARIANCE_SCALE: cfg_vscale = sext24(v);
         CSR_ANGLE_INIT:     lod = clampl(longint'(v[ANGLE_W-1:0]), ANGLE_MIN, ANGLE_MAX);
         default: ;
      endcase
   endfunction

   // one regulator step: averages, noise gated PID, angle update
   function automatic frame_result_type regulate_frame(frame_type f);
      longint pres, eng, bat, gpu, delta, tgt, ss, nb, sb, rt;
      longint now_f, slow_f, dfps, var_q, err, esq, noise, e, dt, integ, deriv;
      longint p, i, dd, sum, old, one_s, dmax_s;
      frame_result_type r;
      // signed copies keep the signed math below out of unsigned context
      one_s  = longint'(ONE_Q16);
      dmax_s = longint'(DELTA_MAX);
      pres  = f.present < 0 ? 0 : f.present;
      eng   = f.engine < 0 ? 0 : f.engine;
      bat   = f.batch < 0 ? 0 : f.batch;
      gpu   = f.gpu < 0 ? 0 : f.gpu;
      delta = clampl(f.delta, 0, DELTA_MAX);
      tgt   = cfg_target < TARGET_MIN ? TARGET_MIN : cfg_target;
      ss    = cfg_smooth < SCALE_MIN ? SCALE_MIN : cfg_smooth;
      old   = lod;
      r.changed = 1'b0;
      r.regulated = 1'b0;
      // present time only counts up to batch time plus the cushion
      if (pres > bat + CUSHION_MS8) pres = bat + CUSHION_MS8;
      rt = pres;
      if (eng > rt) rt = eng;
      if (gpu > rt) rt = gpu;
      rt = clampl(rt, RT_MIN, RT_MAX);
      nb = delta < TIMESCALE_US ? (delta << 16) / TIMESCALE_US : ONE_Q16;
      sb = (delta << 8) < TIMESCALE_US * ss ? (delta << 24) / (TIMESCALE_US * ss) : ONE_Q16;
      fast_avg = blend_avg(fast_avg, nb, rt);
      slow_avg = blend_avg(slow_avg, sb, rt);
      if (cfg_enable != 0 && delta > 0 && fast_avg > 0 && slow_avg > 0) begin
         now_f  = fps_from(fast_avg);
         slow_f = fps_from(slow_avg);
         dfps   = slow_f - now_f;
         var_q  = (dfps * dfps * cfg_vscale) >>> 16;
         err    = tgt - slow_f;
         esq    = err * err;
         noise  = one_s;
         if (esq < var_q) noise = 0;
         else if (esq < 2 * var_q) noise = (esq - var_q) * one_s / var_q;
         e      = clampl(noise * err / tgt, -one_s, one_s);
         dt     = delta < TIMESCALE_US ? delta : TIMESCALE_US;
         integ  = clampl(err_integral + e * dt / dmax_s, -one_s, one_s);
         deriv  = (e - last_err) * dmax_s / dt;
         last_err = e;
         err_integral = integ;
         p   = sat_term((cfg_kp * e) >>> 16);
         i   = sat_term((cfg_ki * integ) >>> 16);
         dd  = sat_term((cfg_kd * deriv) >>> 16);
         sum = sat_term(p + i + dd);
         term_rec[0] = p; term_rec[1] = i; term_rec[2] = dd; term_rec[3] = sum;
         lod = clampl(old + sum, ANGLE_MIN, ANGLE_MAX);
         r.changed = lod != old;
         r.regulated = 1'b1;
      end
      r.angle = lod[ANGLE_W-1:0];
      r.p     = term_rec[0][TERM_W-1:0];
      r.i     = term_rec[1][TERM_W-1:0];
      r.d     = term_rec[2][TERM_W-1:0];
      r.sum   = term_rec[3][TERM_W-1:0];
      r.fast  = fast_avg[AVG_W-1:0];
      r.slow  = slow_avg[AVG_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one request transaction at a time from the frame queue. The
   // expected result is computed at the edge where the transaction is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(regulate_frame(cur_frame));
            frames_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled payload
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (frames_to_send.size() > 0) begin
            cur_frame = frames_to_send.pop_front();
            req_present_time   <= cur_frame.present;
            req_engine_time    <= cur_frame.engine;
            req_batch_time     <= cur_frame.batch;
            req_gpu_time       <= cur_frame.gpu;
            req_frame_delta_us <= cur_frame.delta;
            req_valid <= 1'b1;
            // gap taken after this transaction is accepted
            gap_left <= calm ? 0 : $urandom_range(0, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: random stall per result, field by field compare.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing outstanding");
         end else begin
            want = results_due.pop_front();
            check_field("lod_angle", want.angle, rsp_lod_angle);
            check_field("angle_changed", want.changed, rsp_angle_changed);
            check_field("regulated", want.regulated, rsp_regulated);
            check_field("p_term", want.p, rsp_p_term);
            check_field("i_term", want.i, rsp_i_term);
            check_field("d_term", want.d, rsp_d_term);
            check_field("pid_sum", want.sum, rsp_pid_sum);
            check_field("fast_avg_ms", want.fast, rsp_fast_avg_ms);
            check_field("slow_avg_ms", want.slow, rsp_slow_avg_ms);
            regulated_seen += want.regulated;
            moves_seen += want.changed;
         end
         results_seen++;
         // stall drawn for the next result
         stall_left = calm ? 0 : $urandom_range(0, 3);
         rsp_stall <= stall_left != 0;
      end else if (rsp_valid && rsp_stall) begin
         stall_left = stall_left - 1;
         rsp_stall <= stall_left > 0;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mirror_write(idx, v);
   endtask

   task automatic write_all(logic [CSR_DATA_W-1:0] en, logic [CSR_DATA_W-1:0] tgt,
                            logic [CSR_DATA_W-1:0] ss, logic [CSR_DATA_W-1:0] kp,
                            logic [CSR_DATA_W-1:0] ki, logic [CSR_DATA_W-1:0] kd,
                            logic [CSR_DATA_W-1:0] vs, logic [CSR_DATA_W-1:0] ang);
      csr_write(CSR_AUTO_ENABLE, en);
      csr_write(CSR_TARGET_FPS, tgt);
      csr_write(CSR_SMOOTH_SCALE, ss);
      csr_write(CSR_GAIN_P, kp);
      csr_write(CSR_GAIN_I, ki);
      csr_write(CSR_GAIN_D, kd);
      csr_write(CSR_VARIANCE_SCALE, vs);
      csr_write(CSR_ANGLE_INIT, ang);
   endtask

   // wait until every queued frame is sent and every result is back
   task automatic drain();
      while (frames_to_send.size() > 0 || req_valid || results_due.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void add_frame(longint p, longint e, longint b, longint g, longint d);
      frame_type f;
      f.present = IN_W'(p); f.engine = IN_W'(e); f.batch = IN_W'(b);
      f.gpu = IN_W'(g); f.delta = IN_W'(d);
      frames_to_send.push_back(f);
   endfunction

   function automatic logic [IN_W-1:0] any24();
      return IN_W'($urandom);
   endfunction

   // mostly plausible frame timings, some raw noise across all bits
   function automatic void add_random_frame();
      int unsigned k, kd;
      frame_type f;
      k  = $urandom_range(0, 99);
      kd = $urandom_range(0, 99);
      if (k < 10) begin
         f.present = any24(); f.engine = any24(); f.batch = any24();
         f.gpu = any24(); f.delta = any24();
      end else begin
         f.present = IN_W'($urandom_range(200, 20000));
         f.batch   = IN_W'($urandom_range(0, 18000));
         f.engine  = IN_W'($urandom_range(0, 15000));
         f.gpu     = IN_W'($urandom_range(0, 16000));
         if (kd < 4)       f.delta = '0;
         else if (kd < 8)  f.delta = IN_W'(-$urandom_range(1, 1000));
         else if (kd < 12) f.delta = IN_W'($urandom_range(80000, 1200000));
         else              f.delta = IN_W'($urandom_range(1, 70000));
      end
      frames_to_send.push_back(f);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_gain(int unsigned span);
      return CSR_DATA_W'($urandom_range(0, 2 * span) - span);
   endfunction

   initial begin
      mirror_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under reset settings
      add_frame(0, 0, 0, 0, 0);                         // zero delta, averages still zero
      add_frame(-1, -8388608, -5, -100, 1);              // negatives clamp to zero
      add_frame(8388607, 8388607, 8388607, 8388607, 8388607); // all at maximum
      add_frame(5000, 0, 0, 0, 16667);                   // present capped by cushion
      add_frame(5000, 0, 4000, 0, 16667);
      add_frame(0, 3000, 0, 0, 80000);                   // delta equal to the timescale
      add_frame(0, 0, 0, 9000, 79999);
      add_frame(100, 100, 100, 100, 1000000);            // short frame, fps saturates
      add_frame(100, 100, 100, 100, 1000001);            // delta above range
      add_frame(4000, 4000, 4000, 4000, -1);             // negative delta
      add_frame(0, 300000, 0, 0, 16000);                 // render time at maximum
      add_frame(256, 0, 0, 0, 16000);
      for (int n = 0; n < 8; n++) add_frame(4200, 3800, 3900, 4100, 16667);
      add_frame(-8388608, 8388607, -8388608, 8388607, -8388608);
      drain();

      // lower extremes of the registers
      write_all(24'd1, 24'd0, 24'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'd0);
      repeat (100) add_random_frame();
      drain();

      // upper extremes
      write_all(24'd1, 24'hFFFF, 24'hFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                24'h7FFFFF, 24'h7FFFFF);
      repeat (100) add_random_frame();
      drain();

      // regulation switched off
      csr_write(CSR_AUTO_ENABLE, 24'd0);
      repeat (60) add_random_frame();
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         calm = ph == 2 || ph == 5;
         write_all(24'd1, CSR_DATA_W'($urandom_range(TARGET_MIN, 30000)),
                   CSR_DATA_W'($urandom_range(SCALE_MIN, 4096)),
                   rand_gain(1 << 18), rand_gain(1 << 18), rand_gain(1 << 16),
                   rand_gain(1 << 19), CSR_DATA_W'($urandom_range(0, ANGLE_MAX + 1000)));
         repeat (70) add_random_frame();
         if (ph == 3) drain();   // sender holds off until all results are back
         repeat (70) add_random_frame();
         drain();
      end

      repeat (300) @(posedge clock);
      $display("covered %0d frames, %0d results, %0d regulated, %0d angle moves",
               frames_sent, results_seen, regulated_seen, moves_seen);
      $display("register extremes, regulation off, and 8 random settings");
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, results_due.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== frame_time_pid_detail_regulator_core.f =====
+incdir+hw/rtl
hw/rtl/ftpr_pkg.sv
hw/rtl/ftpr_mul.sv
hw/rtl/ftpr_div.sv
hw/rtl/frame_time_pid_detail_regulator_core.sv
hw/rtl/ftpr_checker.sv
bench/tb_top.sv
